// ===== src/thruster_joystick_mixer_unit_macros.svh =====
// Assertion macros for the thruster joystick mixer unit.
// Included by the top level; relies on signals clk and arst_n in the including scope.
`ifndef THRUSTER_JOYSTICK_MIXER_UNIT_MACROS_SVH
`define THRUSTER_JOYSTICK_MIXER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent, checked on every clock edge outside reset
`define TJM_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("thruster mixer: implication check failed");
// expression must never be true outside reset
`define TJM_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("thruster mixer: forbidden condition seen");
`else
`define TJM_ASSERT_IMPLIES(lbl, ante, cons)
`define TJM_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== src/tjm_pkg.sv =====
// Package for the thruster joystick mixer: config register map, config struct,
// and fixed arithmetic constants. No dependencies.
package tjm_pkg;

	// stick and speed ranges
	localparam logic signed [7:0] STICK_MAX = 8'sd90;
	localparam logic signed [7:0] STICK_MIN = -8'sd90;
	localparam int unsigned SPEED_SPAN = 180;

	// lanes through the mapping pipeline
	localparam int unsigned NUM_LANES  = 3;
	localparam int unsigned LANE_LIFT  = 0;
	localparam int unsigned LANE_LEFT  = 1;
	localparam int unsigned LANE_RIGHT = 2;

	// reciprocal multiply for divide by 3 (exact for magnitudes below 512)
	localparam int unsigned RECIP3_MUL   = 171;
	localparam int unsigned RECIP3_SHIFT = 9;
	// divide by 180 is a shift by 2 then divide by 45 (exact below 74898)
	localparam int unsigned RECIP45_MUL   = 11651;
	localparam int unsigned RECIP45_SHIFT = 19;

	// config register indexes
	typedef enum logic [2:0] {
		CFG_SPEED_LO     = 3'd0,
		CFG_SPEED_HI     = 3'd1,
		CFG_DEAD_ZONE    = 3'd2,
		CFG_SLOW_LIMIT   = 3'd3,
		CFG_INVERT_LIFT  = 3'd4,
		CFG_INVERT_LEFT  = 3'd5,
		CFG_INVERT_RIGHT = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] speed_lo;
		logic [7:0] speed_hi;
		logic [6:0] dead_zone;
		logic [6:0] slow_limit;
		logic       invert_lift;
		logic       invert_left;
		logic       invert_right;
	} cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		speed_lo:     8'd0,
		speed_hi:     8'd180,
		dead_zone:    7'd5,
		slow_limit:   7'd45,
		invert_lift:  1'b0,
		invert_left:  1'b0,
		invert_right: 1'b0
	};

endpackage

// ===== src/thruster_joystick_mixer_unit.sv =====
// Thruster joystick mixer: each accepted sample passes through the pipeline registers named
// below, and done is registered alongside the speeds that it marks.
// Throughput one sample per cycle; busy is never raised and cfg_ready is always high.
// The rate is set by a five-register pipeline: input, mix with divide by three,
// speed-range multiply, divide by 180, offset and inversion.
// arst_n clears all valid flags and loads the config registers with their reset values.
`include "thruster_joystick_mixer_unit_macros.svh"

module thruster_joystick_mixer_unit
	import tjm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// sample request
	input  logic              start,
	output logic              busy,
	input  logic signed [7:0] lift_stick,
	input  logic signed [7:0] forward_stick,
	input  logic signed [7:0] turn_stick,
	input  logic              slow_switch_level,
	// result
	output logic              done,
	output logic [7:0]        lift_speed,
	output logic [7:0]        left_speed,
	output logic [7:0]        right_speed,
	// config write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	// clamp a stick value to the legal range
	function automatic logic signed [7:0] clamp_stick(input logic signed [7:0] v);
		logic signed [7:0] r;
		r = v;
		if (v > STICK_MAX) r = STICK_MAX;
		if (v < STICK_MIN) r = STICK_MIN;
		return r;
	endfunction

	// divide by 3, truncating toward zero; |n| <= 270
	function automatic logic signed [7:0] div3(input logic signed [9:0] n);
		logic        neg;
		logic [8:0]  mag;
		logic [17:0] prod;
		logic [7:0]  q;
		neg  = n[9];
		mag  = neg ? 9'(-n) : n[8:0];
		prod = 18'(mag) * 18'(RECIP3_MUL);
		q    = prod[RECIP3_SHIFT +: 8];
		return neg ? -$signed(q) : $signed(q);
	endfunction

	cfg_regs_t cfg_q;

	logic signed [7:0]  lift_s1, fwd_s1, turn_s1;
	logic               slow_s1, valid_s1;
	logic signed [7:0]  v_s2 [NUM_LANES];
	logic               slow_s2, valid_s2;
	logic signed [17:0] p_s3 [NUM_LANES];
	logic               valid_s3;
	logic signed [8:0]  q_s4 [NUM_LANES];
	logic               valid_s4;
	logic [7:0]         speed_q [NUM_LANES];
	logic               done_q;

	logic               inv [NUM_LANES];
	logic signed [7:0]  mix_v [NUM_LANES];
	logic signed [17:0] prod_c [NUM_LANES];
	logic signed [8:0]  quot_c [NUM_LANES];
	logic [7:0]         speed_c [NUM_LANES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign inv[LANE_LIFT]  = cfg_q.invert_lift;
	assign inv[LANE_LEFT]  = cfg_q.invert_left;
	assign inv[LANE_RIGHT] = cfg_q.invert_right;

	// config register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPEED_LO:     cfg_q.speed_lo     <= cfg_data;
				CFG_SPEED_HI:     cfg_q.speed_hi     <= cfg_data;
				CFG_DEAD_ZONE:    cfg_q.dead_zone    <= cfg_data[6:0];
				CFG_SLOW_LIMIT:   cfg_q.slow_limit   <= cfg_data[6:0];
				CFG_INVERT_LIFT:  cfg_q.invert_lift  <= cfg_data[0];
				CFG_INVERT_LEFT:  cfg_q.invert_left  <= cfg_data[0];
				CFG_INVERT_RIGHT: cfg_q.invert_right <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			lift_s1 <= lift_stick;
			fwd_s1  <= forward_stick;
			turn_s1 <= turn_stick;
			slow_s1 <= ~slow_switch_level;
		end
	end

	// stage 2: clamp and arcade mix
	always_comb begin
		logic signed [7:0] f, t;
		logic signed [8:0] f9, t9, d9, s9;
		logic signed [9:0] f10, t10, ln, rn;
		logic signed [7:0] ld, rd;
		logic tl, tr, turning, z_sf, z_ff, z_sb, z_fb;
		f   = clamp_stick(fwd_s1);
		t   = clamp_stick(turn_s1);
		f9  = {f[7], f};
		t9  = {t[7], t};
		d9  = $signed({2'b00, cfg_q.dead_zone});
		s9  = $signed({2'b00, cfg_q.slow_limit});
		f10 = {f[7], f[7], f};
		t10 = {t[7], t[7], t};
		tl  = t9 <= -d9;
		tr  = !tl && (t9 >= d9);
		turning = tl || tr;
		// forward zones, tested in priority order
		z_sf = (f9 >= d9) && (f9 <= s9);
		z_ff = !z_sf && (f9 > s9);
		z_sb = !z_sf && !z_ff && (f9 <= -d9) && (f9 >= -s9);
		z_fb = !z_sf && !z_ff && !z_sb && (f9 < -s9);
		// slow zones blend f with 2t, fast zones blend 2f with t
		ln = (z_sf || z_sb) ? (f10 + (t10 <<< 1)) : ((f10 <<< 1) + t10);
		rn = (z_sf || z_sb) ? (f10 - (t10 <<< 1)) : ((f10 <<< 1) - t10);
		ld = div3(ln);
		rd = div3(rn);
		mix_v[LANE_LIFT]  = clamp_stick(lift_s1);
		mix_v[LANE_LEFT]  = f;
		mix_v[LANE_RIGHT] = f;
		if (z_sf) begin
			if (turning) begin
				mix_v[LANE_LEFT]  = ld;
				mix_v[LANE_RIGHT] = rd;
			end
		end else if (z_ff || z_fb) begin
			// fast zones: stall the motor on the inside of the turn
			if (tl) begin
				mix_v[LANE_LEFT]  = z_ff ? 8'sd0 : ld;
				mix_v[LANE_RIGHT] = z_ff ? rd : 8'sd0;
			end else if (tr) begin
				mix_v[LANE_LEFT]  = z_ff ? ld : 8'sd0;
				mix_v[LANE_RIGHT] = z_ff ? 8'sd0 : rd;
			end
		end else if (z_sb) begin
			if (tl) begin
				mix_v[LANE_LEFT]  = ld;
				mix_v[LANE_RIGHT] = 8'sd0;
			end else if (tr) begin
				mix_v[LANE_LEFT]  = 8'sd0;
				mix_v[LANE_RIGHT] = rd;
			end
		end else begin
			// center zone: spin in place or stop
			mix_v[LANE_LEFT]  = turning ? t : 8'sd0;
			mix_v[LANE_RIGHT] = turning ? -t : 8'sd0;
		end
	end

	always_ff @(posedge clk) begin
		v_s2    <= mix_v;
		slow_s2 <= slow_s1;
	end

	// stage 3: halve in slow mode, add 90, then scale by the speed span
	always_comb begin
		logic signed [8:0] span;
		span = $signed({1'b0, cfg_q.speed_hi}) - $signed({1'b0, cfg_q.speed_lo});
		for (int i = 0; i < NUM_LANES; i++) begin
			logic signed [8:0] v9, sum9, h9, u9;
			v9   = {v_s2[i][7], v_s2[i]};
			sum9 = v9 + $signed({8'd0, v_s2[i][7]});
			h9   = slow_s2 ? (sum9 >>> 1) : v9;
			u9   = h9 + 9'sd90;
			prod_c[i] = $signed({1'b0, u9[7:0]}) * span;
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= prod_c;
	end

	// stage 4: divide by 180 toward zero
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			logic        neg;
			logic [17:0] mag18;
			logic [13:0] y;
			logic [28:0] prod;
			logic [7:0]  qa;
			neg   = p_s3[i][17];
			mag18 = neg ? 18'(-p_s3[i]) : 18'(p_s3[i]);
			y     = mag18[15:2];
			prod  = 29'(y) * 29'(RECIP45_MUL);
			qa    = prod[RECIP45_SHIFT +: 8];
			quot_c[i] = neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
		end
	end

	always_ff @(posedge clk) begin
		q_s4 <= quot_c;
	end

	// stage 5: add the range offset, optional inversion saturating at zero
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			logic signed [9:0]  m10;
			logic signed [10:0] d11;
			m10 = {q_s4[i][8], q_s4[i]} + $signed({2'b00, cfg_q.speed_lo});
			d11 = 11'(SPEED_SPAN) - {m10[9], m10};
			if (inv[i]) begin
				speed_c[i] = d11[10] ? 8'd0 : d11[7:0];
			end else begin
				speed_c[i] = m10[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		speed_q <= speed_c;
	end

	// valid flags along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	assign done        = done_q;
	assign lift_speed  = speed_q[LANE_LIFT];
	assign left_speed  = speed_q[LANE_LEFT];
	assign right_speed = speed_q[LANE_RIGHT];

	// every accepted request yields exactly one result on done
	`TJM_ASSERT_IMPLIES(a_result_follows, start && !busy, ##5 done)
	`TJM_ASSERT_IMPLIES(a_result_has_request, done, $past(start, 5))
	// inverted left output never exceeds the span
	`TJM_ASSERT_NEVER(a_inv_left_range, done && cfg_q.invert_left && (left_speed > 8'd180))
	// uninverted right output stays inside an upward speed range
	`TJM_ASSERT_IMPLIES(a_right_in_range,
		done && !cfg_q.invert_right && (cfg_q.speed_hi >= cfg_q.speed_lo),
		(right_speed >= cfg_q.speed_lo) && (right_speed <= cfg_q.speed_hi))

endmodule
